### hw/rtl/rtt_pkg.sv
// Shared types and constants for the repeating timer table.
package rtt_pkg;

  // Slot field is three bits wide, so at most eight slots can ever be addressed
  localparam int SLOT_LIMIT = 8;

  // Request codes carried in req_type
  typedef enum logic [2:0] {
    REQ_TICK      = 3'd0,
    REQ_SCHED_ABS = 3'd1,
    REQ_SCHED_REL = 3'd2,
    REQ_REMOVE    = 3'd3,
    REQ_CLEAR     = 3'd4
  } rtt_req_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } rtt_state_t;

  // Input request
  typedef struct packed {
    logic [2:0]         req_type;
    logic [2:0]         slot;
    logic [31:0]        now;
    logic [31:0]        fire_time;
    logic signed [15:0] repeat_limit;
    logic [31:0]        interval;
  } rtt_in_t;

  // One firing result
  typedef struct packed {
    logic [2:0] fired_slot;
    logic       done_res;
    logic       last;
  } rtt_out_t;

  // Status from the shared slot unit
  typedef struct packed {
    logic hit;   // current time has reached the fire time
    logic more;  // slot repeats after this firing
  } rtt_alu_st_t;

endpackage

### hw/rtl/rtt_slot_alu.sv
// Shared slot arithmetic: time compare, time advance adder, fire count and limit check.
module rtt_slot_alu import rtt_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic [TIME_BITS-1:0] cmp_now,
  input  logic [TIME_BITS-1:0] cmp_time,
  input  logic [TIME_BITS-1:0] add_a,
  input  logic [TIME_BITS-1:0] add_b,
  input  logic signed [15:0]   limit,
  input  logic [15:0]          count,
  output logic [TIME_BITS-1:0] sum,
  output logic [15:0]          count_nxt,
  output rtt_alu_st_t          st
);

  // Adder wraps modulo 2^TIME_BITS; shared by relative scheduling and time advance
  assign sum = add_a + add_b;

  // Fire count saturates at all ones
  assign count_nxt = (count == 16'hFFFF) ? count : count + 16'd1;

  // Negative limit repeats forever, otherwise repeat while limit exceeds the count
  always_comb begin
    st.hit  = (cmp_now >= cmp_time);
    st.more = limit[15] | ({1'b0, limit[14:0]} > count_nxt);
  end

endmodule

### hw/rtl/repeating_timer_table.sv
// Top level of the repeating timer table: slot store, walk sequencer and result register.
// Schedule, remove and clear requests take effect when accepted. A tick request walks the
// slots one per cycle through a single shared compare/add unit, pausing while out_ready
// low keeps an earlier result from the result register, and keeps the input busy until
// the walk and final flush are done. Firing results come out in ascending slot order; the
// last result of a tick is marked with last, and a tick with no due slot produces no
// result. The result register lets the next request in while the final result waits.
module repeating_timer_table import rtt_pkg::*; #(
  parameter int NUM_SLOTS = 8,
  parameter int TIME_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rtt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rtt_out_t out_data
);

  localparam int DEPTH = (NUM_SLOTS < SLOT_LIMIT) ? NUM_SLOTS : SLOT_LIMIT;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

  // Control state
  rtt_state_t           state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [DEPTH-1:0]     valid_r, valid_nxt;
  logic [TIME_BITS-1:0] last_tick_r, last_tick_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [2:0]           pend_slot_r, pend_slot_nxt;
  logic                 pend_done_r, pend_done_nxt;
  logic                 out_valid_r, out_valid_nxt;
  rtt_out_t             out_data_r, out_data_nxt;

  // Slot payload, undefined until scheduled
  logic [TIME_BITS-1:0] ftime_r [DEPTH];
  logic [TIME_BITS-1:0] ival_r  [DEPTH];
  logic signed [15:0]   limit_r [DEPTH];
  logic [15:0]          count_r [DEPTH];

  logic                 acc;
  logic                 slot_ok;
  logic [IDX_W-1:0]     slot_idx;
  logic                 do_load;
  logic [TIME_BITS-1:0] load_time;
  logic                 do_fire;
  logic                 out_free;
  logic [TIME_BITS-1:0] add_a, add_b, sum;
  logic [15:0]          count_nxt;
  rtt_alu_st_t          alu_st;

  assign acc      = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign slot_ok  = ({1'b0, in_data.slot} < 4'(DEPTH));
  assign slot_idx = in_data.slot[IDX_W-1:0];
  assign out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Adder operands: time advance while walking, relative schedule otherwise
  always_comb begin
    if (state_r == ST_WALK) begin
      add_a = ftime_r[idx_r];
      add_b = ival_r[idx_r];
    end else begin
      add_a = last_tick_r;
      add_b = TIME_BITS'(in_data.fire_time);
    end
  end

  rtt_slot_alu #(
    .TIME_BITS(TIME_BITS)
  ) u_alu (
    .cmp_now  (last_tick_r),
    .cmp_time (ftime_r[idx_r]),
    .add_a    (add_a),
    .add_b    (add_b),
    .limit    (limit_r[idx_r]),
    .count    (count_r[idx_r]),
    .sum      (sum),
    .count_nxt(count_nxt),
    .st       (alu_st)
  );

  // Sequencer: request decode, slot walk and result hand-off
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    valid_nxt     = valid_r;
    last_tick_nxt = last_tick_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    pend_done_nxt = pend_done_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    do_load       = 1'b0;
    load_time     = TIME_BITS'(in_data.fire_time);
    do_fire       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          unique case (in_data.req_type)
            REQ_TICK: begin
              last_tick_nxt = TIME_BITS'(in_data.now);
              idx_nxt       = '0;
              state_nxt     = ST_WALK;
            end
            REQ_SCHED_ABS: begin
              do_load = slot_ok;
            end
            REQ_SCHED_REL: begin
              do_load   = slot_ok;
              load_time = sum;
            end
            REQ_REMOVE: begin
              if (slot_ok) valid_nxt[slot_idx] = 1'b0;
            end
            REQ_CLEAR: begin
              valid_nxt = '0;
            end
            default: ;
          endcase
          if (do_load) valid_nxt[slot_idx] = 1'b1;
        end
      end

      ST_WALK: begin
        // hold while an earlier result cannot move to the output register
        if (!(valid_r[idx_r] && alu_st.hit && pend_v_r && !out_free)) begin
          if (valid_r[idx_r] && alu_st.hit) begin
            do_fire = 1'b1;
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{fired_slot: pend_slot_r, done_res: pend_done_r, last: 1'b0};
            end
            pend_v_nxt    = 1'b1;
            pend_slot_nxt = 3'(idx_r);
            pend_done_nxt = !alu_st.more;
            if (!alu_st.more) valid_nxt[idx_r] = 1'b0;
          end
          if (idx_r == IDX_LAST) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{fired_slot: pend_slot_r, done_res: pend_done_r, last: 1'b1};
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      valid_r     <= '0;
      last_tick_r <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      valid_r     <= valid_nxt;
      last_tick_r <= last_tick_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    pend_slot_r <= pend_slot_nxt;
    pend_done_r <= pend_done_nxt;
    out_data_r  <= out_data_nxt;
  end

  // Slot store: load on schedule, update on firing
  always_ff @(posedge clk) begin
    if (do_load) begin
      ftime_r[slot_idx] <= load_time;
      ival_r[slot_idx]  <= TIME_BITS'(in_data.interval);
      limit_r[slot_idx] <= in_data.repeat_limit;
      count_r[slot_idx] <= '0;
    end else if (do_fire) begin
      count_r[idx_r] <= count_nxt;
      if (alu_st.more) ftime_r[idx_r] <= sum;
    end
  end

endmodule
